FILE: rtl/srsd_pkg.sv
// ----------------------------------------------------------------------------
// srsd_pkg: shared definitions of the range scan decoder
// Field widths, protocol constants and register indexes used by the
// channel interfaces, the decoder and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package srsd_pkg;

  // Reply framing.
  localparam int HEADER_BYTES = 29;
  localparam int MAX_POINTS   = 1024;

  // Field widths.
  localparam int BYTE_W      = 8;
  localparam int START_W     = 10;
  localparam int CLUSTER_W   = 5;
  localparam int DIST_W      = 18;
  localparam int ANGLE_W     = 16;
  localparam int POINT_W     = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 18;
  localparam int HDR_W       = 5;
  localparam int GROUP_W     = 11;
  localparam int KEPT_W      = 11;
  localparam int SIX_W       = 6;

  // Character coding.
  localparam logic [BYTE_W-1:0]  LINE_FEED       = 8'h0A;
  localparam logic [SIX_W-1:0]   CHAR_BIAS       = 6'h30;
  localparam logic [ANGLE_W-1:0] ANGLE_ORIGIN    = 16'd384;
  localparam logic [GROUP_W-1:0] GROUP_INDEX_MAX = 11'd2047;

  // Register reset values.
  localparam logic [START_W-1:0]   START_STEP_RST   = 10'd0;
  localparam logic [CLUSTER_W-1:0] CLUSTER_STEP_RST = 5'd4;
  localparam logic [DIST_W-1:0]    MIN_DIST_RST     = 18'd30;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_STEP   = 2'd0,
    CFG_CLUSTER_STEP = 2'd1,
    CFG_MIN_DISTANCE = 2'd2
  } cfg_index_t;

endpackage

`default_nettype wire

FILE: rtl/srsd_channel_if.sv
// ----------------------------------------------------------------------------
// srsd_channel_if: valid/ready channels of the range scan decoder
// Byte input channel, point result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Received bytes of a scanner reply.
interface srsd_byte_if;
  logic                         valid;
  logic                         ready;
  logic [srsd_pkg::BYTE_W-1:0]  rx_byte;
  logic                         frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Decoded points.
interface srsd_point_if;
  logic                                valid;
  logic                                ready;
  logic        [srsd_pkg::DIST_W-1:0]  distance_mm;
  logic signed [srsd_pkg::ANGLE_W-1:0] angle_steps;
  logic        [srsd_pkg::POINT_W-1:0] point_number;

  modport source (output valid, output distance_mm, output angle_steps,
                  output point_number, input ready);
  modport sink   (input valid, input distance_mm, input angle_steps,
                  input point_number, output ready);
endinterface

// Configuration register writes.
interface srsd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [srsd_pkg::CFG_IDX_W-1:0]   index;
  logic [srsd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/scip_range_scan_decoder.sv
// ----------------------------------------------------------------------------
// scip_range_scan_decoder: three-character range reply decoder
// Strips the reply header and per-line check bytes, decodes distance groups
// and emits kept points with their angle and point number.
// ----------------------------------------------------------------------------
// The decoder takes one reply byte per clock cycle unless a stalled point holds
// off its input. A group's last character is held back one byte, so a kept
// point is decoded at the transaction of the next non-line-feed byte and is
// registered before it shows on the point channel. All decode state is updated
// in a single pass at the byte transaction, and the result sits in an output
// register; a new byte is taken whenever that register is empty or is being
// read in the same cycle, so throughput is one byte per cycle as long as the
// point sink keeps up. Each line's last character before a line feed is held
// back one byte and dropped as the check byte. A byte flagged frame_start
// clears all counters and starts the header skip. Configuration writes are
// always accepted and take effect on the next byte.
`default_nettype none

module scip_range_scan_decoder (
  input  wire          clk,
  input  wire          rst_n,
  srsd_byte_if.sink    in_ch,
  srsd_point_if.source out_ch,
  srsd_cfg_if.sink     cfg_ch
);

  // Configuration registers.
  logic [srsd_pkg::START_W-1:0]   start_step_r;
  logic [srsd_pkg::CLUSTER_W-1:0] cluster_step_r;
  logic [srsd_pkg::DIST_W-1:0]    min_distance_r;

  // Decode state.
  logic [srsd_pkg::HDR_W-1:0]   header_left_r,  header_left_nxt;
  logic [srsd_pkg::BYTE_W-1:0]  held_char_r,    held_char_nxt;
  logic                         held_valid_r,   held_valid_nxt;
  logic [2*srsd_pkg::SIX_W-1:0] group_bits_r,   group_bits_nxt;
  logic [1:0]                   group_pos_r,    group_pos_nxt;
  logic [srsd_pkg::GROUP_W-1:0] group_index_r,  group_index_nxt;
  logic [srsd_pkg::ANGLE_W-1:0] angle_acc_r,    angle_acc_nxt;
  logic [srsd_pkg::KEPT_W-1:0]  kept_count_r,   kept_count_nxt;

  // Result register.
  logic                          out_valid_r,  out_valid_nxt;
  logic [srsd_pkg::DIST_W-1:0]   out_dist_r,   out_dist_nxt;
  logic [srsd_pkg::ANGLE_W-1:0]  out_angle_r,  out_angle_nxt;
  logic [srsd_pkg::POINT_W-1:0]  out_point_r,  out_point_nxt;

  // Per-byte decode signals.
  logic                         in_accept;
  logic [srsd_pkg::HDR_W-1:0]   hdr_eff;
  logic                         held_valid_eff;
  logic [srsd_pkg::BYTE_W-1:0]  held_char_eff;
  logic [2*srsd_pkg::SIX_W-1:0] group_bits_eff;
  logic [1:0]                   group_pos_eff;
  logic [srsd_pkg::GROUP_W-1:0] group_index_eff;
  logic [srsd_pkg::ANGLE_W-1:0] angle_acc_eff;
  logic [srsd_pkg::KEPT_W-1:0]  kept_count_eff;
  logic [srsd_pkg::SIX_W-1:0]   six;
  logic [srsd_pkg::DIST_W-1:0]  group_dist;
  logic [srsd_pkg::ANGLE_W-1:0] angle;
  logic                         keep;

  // Handshakes: bytes flow while the result register is free or draining.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_accept    = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.distance_mm  = out_dist_r;
  assign out_ch.angle_steps  = out_angle_r;
  assign out_ch.point_number = out_point_r;

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_step_r   <= srsd_pkg::START_STEP_RST;
      cluster_step_r <= srsd_pkg::CLUSTER_STEP_RST;
      min_distance_r <= srsd_pkg::MIN_DIST_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        srsd_pkg::CFG_START_STEP: begin
          start_step_r <= cfg_ch.data[srsd_pkg::START_W-1:0];
        end
        srsd_pkg::CFG_CLUSTER_STEP: begin
          cluster_step_r <= cfg_ch.data[srsd_pkg::CLUSTER_W-1:0];
        end
        srsd_pkg::CFG_MIN_DISTANCE: begin
          min_distance_r <= cfg_ch.data[srsd_pkg::DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // State as seen by this byte: a frame start clears everything first.
  always_comb begin
    if (in_ch.frame_start) begin
      hdr_eff         = srsd_pkg::HDR_W'(srsd_pkg::HEADER_BYTES);
      held_valid_eff  = 1'b0;
      held_char_eff   = '0;
      group_bits_eff  = '0;
      group_pos_eff   = '0;
      group_index_eff = '0;
      angle_acc_eff   = '0;
      kept_count_eff  = '0;
    end else begin
      hdr_eff         = header_left_r;
      held_valid_eff  = held_valid_r;
      held_char_eff   = held_char_r;
      group_bits_eff  = group_bits_r;
      group_pos_eff   = group_pos_r;
      group_index_eff = group_index_r;
      angle_acc_eff   = angle_acc_r;
      kept_count_eff  = kept_count_r;
    end
  end

  // Character value, completed distance, angle and keep decision.
  assign six        = held_char_eff[srsd_pkg::SIX_W-1:0] - srsd_pkg::CHAR_BIAS;
  assign group_dist = {group_bits_eff, six};
  assign angle = srsd_pkg::ANGLE_W'(start_step_r) - srsd_pkg::ANGLE_ORIGIN + angle_acc_eff;
  assign keep  = (group_dist > min_distance_r) &&
                 (kept_count_eff < srsd_pkg::KEPT_W'(srsd_pkg::MAX_POINTS));

  // Next decode state and result for the byte in this transaction.
  always_comb begin
    header_left_nxt = header_left_r;
    held_char_nxt   = held_char_r;
    held_valid_nxt  = held_valid_r;
    group_bits_nxt  = group_bits_r;
    group_pos_nxt   = group_pos_r;
    group_index_nxt = group_index_r;
    angle_acc_nxt   = angle_acc_r;
    kept_count_nxt  = kept_count_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_dist_nxt    = out_dist_r;
    out_angle_nxt   = out_angle_r;
    out_point_nxt   = out_point_r;

    if (in_accept) begin
      header_left_nxt = hdr_eff;
      held_char_nxt   = held_char_eff;
      held_valid_nxt  = held_valid_eff;
      group_bits_nxt  = group_bits_eff;
      group_pos_nxt   = group_pos_eff;
      group_index_nxt = group_index_eff;
      angle_acc_nxt   = angle_acc_eff;
      kept_count_nxt  = kept_count_eff;

      if (hdr_eff != '0) begin
        // Still inside the header.
        header_left_nxt = hdr_eff - 1'b1;
      end else if (in_ch.rx_byte == srsd_pkg::LINE_FEED) begin
        // End of line: the held byte is the check character.
        held_valid_nxt = 1'b0;
        held_char_nxt  = '0;
      end else begin
        if (held_valid_eff) begin
          if (group_pos_eff != 2'd2) begin
            group_bits_nxt = {group_bits_eff[srsd_pkg::SIX_W-1:0], six};
            group_pos_nxt  = group_pos_eff + 1'b1;
          end else begin
            group_bits_nxt = '0;
            group_pos_nxt  = '0;
            if (keep) begin
              out_valid_nxt  = 1'b1;
              out_dist_nxt   = group_dist;
              out_angle_nxt  = angle;
              out_point_nxt  = kept_count_eff[srsd_pkg::POINT_W-1:0];
              kept_count_nxt = kept_count_eff + 1'b1;
            end
            if (group_index_eff != srsd_pkg::GROUP_INDEX_MAX) begin
              group_index_nxt = group_index_eff + 1'b1;
              angle_acc_nxt   = angle_acc_eff + srsd_pkg::ANGLE_W'(cluster_step_r);
            end
          end
        end
        held_char_nxt  = in_ch.rx_byte;
        held_valid_nxt = 1'b1;
      end
    end
  end

  // Decode state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_left_r <= '0;
      held_char_r   <= '0;
      held_valid_r  <= 1'b0;
      group_bits_r  <= '0;
      group_pos_r   <= '0;
      group_index_r <= '0;
      angle_acc_r   <= '0;
      kept_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      header_left_r <= header_left_nxt;
      held_char_r   <= held_char_nxt;
      held_valid_r  <= held_valid_nxt;
      group_bits_r  <= group_bits_nxt;
      group_pos_r   <= group_pos_nxt;
      group_index_r <= group_index_nxt;
      angle_acc_r   <= angle_acc_nxt;
      kept_count_r  <= kept_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_dist_r  <= out_dist_nxt;
    out_angle_r <= out_angle_nxt;
    out_point_r <= out_point_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/srsd_checker.sv
// ----------------------------------------------------------------------------
// srsd_checker: port-level checks of the range scan decoder
// Watches the channel handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module srsd_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire        [srsd_pkg::DIST_W-1:0]  out_distance_mm,
  input wire signed [srsd_pkg::ANGLE_W-1:0] out_angle_steps,
  input wire        [srsd_pkg::POINT_W-1:0] out_point_number,
  input wire                                cfg_ready
);

  // A stalled point keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_mm) &&
      $stable(out_angle_steps) && $stable(out_point_number))
    else $error("stalled point changed");

  // A new point only follows a byte transaction.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("point appeared without a byte transaction");

  // With the result register empty or draining, the byte input is always ready.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("byte input stalled with free result register");

  // Configuration writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind scip_range_scan_decoder srsd_checker u_srsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_distance_mm  (out_ch.distance_mm),
  .out_angle_steps  (out_ch.angle_steps),
  .out_point_number (out_ch.point_number),
  .cfg_ready        (cfg_ch.ready)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the range scan decoder
// Feeds scanner replies, with headers, check bytes, line feeds and noise, into
// the byte channel under changing register settings, predicts every kept
// point and compares each point transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 10;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int MAX_REPORTS     = 10;
  localparam int LONG_GROUPS     = 80;

  // Register index that the decoder does not implement.
  localparam logic [srsd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Characters whose six-bit values are 0 and 63.
  localparam logic [srsd_pkg::BYTE_W-1:0] DIGIT_LO = 8'h30;
  localparam logic [srsd_pkg::BYTE_W-1:0] DIGIT_HI = 8'h6F;

  // Bytes sent right after reset, before any reply has started.
  localparam logic [srsd_pkg::BYTE_W-1:0] NO_FRAME_BYTES [24] = '{
    // An all-zero group is at or below the minimum and is dropped.
    DIGIT_LO, DIGIT_LO, DIGIT_LO, 8'h41, srsd_pkg::LINE_FEED,
    // A second line feed with nothing held.
    srsd_pkg::LINE_FEED,
    // The largest distance.
    DIGIT_HI, DIGIT_HI, DIGIT_HI, DIGIT_LO, srsd_pkg::LINE_FEED,
    // Bytes outside the digit range wrap modulo 64.
    8'h00, 8'hFF, 8'h80, 8'h7F, srsd_pkg::LINE_FEED,
    // One above the minimum, then exactly at it.
    DIGIT_LO, DIGIT_LO, 8'h4F, DIGIT_LO, DIGIT_LO, 8'h4E, 8'h31, srsd_pkg::LINE_FEED
  };

  typedef struct packed {
    logic [srsd_pkg::DIST_W-1:0]  distance;
    logic [srsd_pkg::ANGLE_W-1:0] angle;
    logic [srsd_pkg::POINT_W-1:0] number;
  } scan_point_t;

  typedef struct packed {
    logic                        frame;
    logic [srsd_pkg::BYTE_W-1:0] data;
  } rx_item_t;

  // Predicts kept points from accepted bytes and checks point transactions.
  class scan_point_scoreboard;
    logic [srsd_pkg::START_W-1:0]   start_step;
    logic [srsd_pkg::CLUSTER_W-1:0] cluster_step;
    logic [srsd_pkg::DIST_W-1:0]    min_distance;
    logic [srsd_pkg::HDR_W-1:0]     header_left;
    logic [srsd_pkg::BYTE_W-1:0]    held_char;
    logic                           held_valid;
    logic [2*srsd_pkg::SIX_W-1:0]   group_bits;
    logic [1:0]                     group_pos;
    logic [srsd_pkg::GROUP_W-1:0]   group_index;
    logic [srsd_pkg::ANGLE_W-1:0]   angle_acc;
    logic [srsd_pkg::KEPT_W-1:0]    kept_count;
    scan_point_t                    pending_points[$];
    int                             mismatch_count;

    function new();
      start_step     = srsd_pkg::START_STEP_RST;
      cluster_step   = srsd_pkg::CLUSTER_STEP_RST;
      min_distance   = srsd_pkg::MIN_DIST_RST;
      mismatch_count = 0;
      clear_reply();
    endfunction

    function void clear_reply();
      header_left = '0;
      held_char   = '0;
      held_valid  = 1'b0;
      group_bits  = '0;
      group_pos   = '0;
      group_index = '0;
      angle_acc   = '0;
      kept_count  = '0;
    endfunction

    function void write_register(logic [srsd_pkg::CFG_IDX_W-1:0] index,
                                 logic [srsd_pkg::CFG_DATA_W-1:0] data);
      case (index)
        srsd_pkg::CFG_START_STEP:   start_step = data[srsd_pkg::START_W-1:0];
        srsd_pkg::CFG_CLUSTER_STEP: cluster_step = data[srsd_pkg::CLUSTER_W-1:0];
        srsd_pkg::CFG_MIN_DISTANCE: min_distance = data[srsd_pkg::DIST_W-1:0];
        default: ;
      endcase
    endfunction

    // Adds one character to the current group; a full group may give a point.
    function void take_char(logic [srsd_pkg::BYTE_W-1:0] c);
      logic [srsd_pkg::SIX_W-1:0]  six;
      logic [srsd_pkg::DIST_W-1:0] group_dist;
      scan_point_t                 pt;
      six = c[srsd_pkg::SIX_W-1:0] - srsd_pkg::CHAR_BIAS;
      if (group_pos != 2'd2) begin
        group_bits = {group_bits[srsd_pkg::SIX_W-1:0], six};
        group_pos  = group_pos + 2'd1;
      end else begin
        group_dist = {group_bits, six};
        group_bits = '0;
        group_pos  = '0;
        if (group_dist > min_distance && kept_count < srsd_pkg::MAX_POINTS) begin
          pt.distance = group_dist;
          pt.angle    = srsd_pkg::ANGLE_W'(start_step) - srsd_pkg::ANGLE_ORIGIN + angle_acc;
          pt.number   = kept_count[srsd_pkg::POINT_W-1:0];
          pending_points.push_back(pt);
          kept_count++;
        end
        if (group_index != srsd_pkg::GROUP_INDEX_MAX) begin
          group_index++;
          angle_acc = angle_acc + srsd_pkg::ANGLE_W'(cluster_step);
        end
      end
    endfunction

    function void note_byte(rx_item_t item);
      if (item.frame) begin
        clear_reply();
        header_left = srsd_pkg::HDR_W'(srsd_pkg::HEADER_BYTES);
      end
      if (header_left != '0) begin
        header_left--;
      end else if (item.data == srsd_pkg::LINE_FEED) begin
        // The held byte is the line's check character.
        held_valid = 1'b0;
        held_char  = '0;
      end else begin
        if (held_valid) take_char(held_char);
        held_char  = item.data;
        held_valid = 1'b1;
      end
    endfunction

    function void report(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
    endfunction

    function void check_point(scan_point_t got);
      scan_point_t want;
      if (pending_points.size() == 0) begin
        report($sformatf("unexpected point: distance %0d angle %0d number %0d",
                         got.distance, $signed(got.angle), got.number));
      end else begin
        want = pending_points.pop_front();
        if (got.distance !== want.distance || got.angle !== want.angle ||
            got.number !== want.number) begin
          report($sformatf({"point mismatch: expected distance %0d angle %0d number %0d,",
                            " got distance %0d angle %0d number %0d"},
                           want.distance, $signed(want.angle), want.number,
                           got.distance, $signed(got.angle), got.number));
        end
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  srsd_byte_if  byte_ch ();
  srsd_point_if point_ch ();
  srsd_cfg_if   cfg_ch ();

  scan_point_scoreboard point_sb;
  rx_item_t             stim_items[$];
  bit                   idling_on;
  bit                   hold_off_request;

  scip_range_scan_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (point_ch),
    .cfg_ch (cfg_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Observe every transaction on the three channels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) point_sb.write_register(cfg_ch.index, cfg_ch.data);
      if (point_ch.valid && point_ch.ready) begin
        point_sb.check_point({point_ch.distance_mm, point_ch.angle_steps,
                              point_ch.point_number});
      end
      if (byte_ch.valid && byte_ch.ready) begin
        point_sb.note_byte({byte_ch.frame_start, byte_ch.rx_byte});
      end
    end
  end

  // Point receiver: random stall bursts and, on request, one long hold-off.
  initial begin : point_receiver
    point_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        point_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        point_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        point_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // End the run if no transaction happens for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (point_ch.valid && point_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic void add_item(input logic [srsd_pkg::BYTE_W-1:0] data, input logic frame);
    stim_items.push_back({frame, data});
  endfunction

  // Mostly digit characters; in noisy replies any byte but a line feed.
  function automatic logic [srsd_pkg::BYTE_W-1:0] data_char(input bit wide);
    logic [srsd_pkg::BYTE_W-1:0] c;
    if (wide && $urandom_range(0, 4) == 0) begin
      c = srsd_pkg::BYTE_W'($urandom);
      if (c == srsd_pkg::LINE_FEED) c = DIGIT_LO;
    end else begin
      c = srsd_pkg::BYTE_W'($urandom_range(DIGIT_LO, DIGIT_HI));
    end
    return c;
  endfunction

  // One reply: flagged header, then lines of characters, check byte and line feed.
  function automatic void build_reply(input int n_groups, input bit noisy);
    int line_left;
    int i;
    line_left = $urandom_range(1, 64);
    add_item(srsd_pkg::BYTE_W'($urandom), 1'b1);
    for (i = 1; i < srsd_pkg::HEADER_BYTES; i++)
      add_item(srsd_pkg::BYTE_W'($urandom), noisy && $urandom_range(0, 60) == 0);
    for (i = 0; i < 3 * n_groups; i++) begin
      add_item(data_char(noisy), 1'b0);
      line_left--;
      if (line_left == 0 || i == 3 * n_groups - 1) begin
        add_item(data_char(noisy), 1'b0);
        add_item(srsd_pkg::LINE_FEED, 1'b0);
        if (noisy && $urandom_range(0, 9) == 0) add_item(srsd_pkg::LINE_FEED, 1'b0);
        line_left = $urandom_range(1, 64);
      end
    end
    // Now and then a reply breaks off early.
    if (noisy && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, stim_items.size() - 1)) void'(stim_items.pop_back());
  endfunction

  function automatic void build_noise(input int count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0)
        add_item(srsd_pkg::LINE_FEED, $urandom_range(0, 39) == 0);
      else
        add_item(srsd_pkg::BYTE_W'($urandom), $urandom_range(0, 39) == 0);
    end
  endfunction

  // Offer the queued bytes one by one; valid stays high after the last one.
  task automatic send_items();
    rx_item_t item;
    while (stim_items.size() != 0) begin
      item = stim_items.pop_front();
      if (idling_on && $urandom_range(0, 7) == 0) begin
        byte_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      byte_ch.valid       <= 1'b1;
      byte_ch.rx_byte     <= item.data;
      byte_ch.frame_start <= item.frame;
      @(posedge clk);
      while (!byte_ch.ready) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted point has been checked.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (point_sb.pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [srsd_pkg::CFG_IDX_W-1:0] index,
                           input logic [srsd_pkg::CFG_DATA_W-1:0] data, input bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  // Upper data bits above a register's width are random and must be ignored.
  task automatic apply_settings(input int start, input int cluster, input int min_dist);
    cfg_write(srsd_pkg::CFG_START_STEP,
              srsd_pkg::CFG_DATA_W'(start) |
              (srsd_pkg::CFG_DATA_W'($urandom_range(0, 255)) << srsd_pkg::START_W), 1'b0);
    cfg_write(srsd_pkg::CFG_CLUSTER_STEP,
              srsd_pkg::CFG_DATA_W'(cluster) |
              (srsd_pkg::CFG_DATA_W'($urandom_range(0, 8191)) << srsd_pkg::CLUSTER_W),
              1'b0);
    cfg_write(srsd_pkg::CFG_MIN_DISTANCE, srsd_pkg::CFG_DATA_W'(min_dist), 1'b1);
  endtask

  task automatic run_phase(input int start, input int cluster, input int min_dist,
                           input int replies, input int max_groups);
    apply_settings(start, cluster, min_dist);
    repeat (replies) begin
      build_reply($urandom_range(1, max_groups), $urandom_range(0, 2) == 0);
      send_items();
      if ($urandom_range(0, 2) == 0) begin
        build_noise($urandom_range(5, 30));
        send_items();
      end
    end
    wait_drained();
  endtask

  initial begin : stimulus
    point_sb = new();
    idling_on        = 1'b1;
    hold_off_request = 1'b0;
    byte_ch.valid       <= 1'b0;
    byte_ch.rx_byte     <= '0;
    byte_ch.frame_start <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= srsd_pkg::CFG_START_STEP;
    cfg_ch.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any reply starts, bytes decode as data under reset settings.
    foreach (NO_FRAME_BYTES[i]) add_item(NO_FRAME_BYTES[i], 1'b0);
    send_items();
    wait_drained();
    cfg_write(CFG_UNUSED, srsd_pkg::CFG_DATA_W'($urandom), 1'b1);

    // Register extremes, including a zero cluster step and the largest minimum distance.
    run_phase(0, 1, 0, 2, 40);
    run_phase(768, 16, 262143, 1, 30);
    run_phase(1023, 0, 30, 2, 40);

    // The receiver holds off while bytes keep coming, so the input stalls.
    idling_on        = 1'b0;
    hold_off_request = 1'b1;
    run_phase(384, 31, $urandom_range(0, 131071), 2, 60);

    // One long reply with many lines and a minimum distance of zero, so every non-zero point is kept.
    apply_settings($urandom_range(0, 768), 16, 0);
    build_reply(LONG_GROUPS, 1'b0);
    send_items();
    wait_drained();
    idling_on = 1'b1;

    run_phase($urandom_range(0, 768), $urandom_range(1, 16), $urandom_range(0, 200000),
              $urandom_range(1, 2), 40);

    // Final stretch at full rate.
    idling_on = 1'b0;
    run_phase($urandom_range(0, 768), $urandom_range(1, 16), $urandom_range(0, 200000),
              2, 40);

    if (point_sb.mismatch_count == 0 && point_sb.pending_points.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
